FILE: hdl/pdacc_pkg.sv
// Package with shared types and constants of the Poisson deviance accumulator.
package pdacc_pkg;

    localparam int unsigned SUM_W = 48;
    localparam int unsigned LOG_FRAC = 24;
    localparam int unsigned LOG_W = 29;
    localparam logic [31:0] LN2_Q32 = 32'd2977044472;
    localparam logic [SUM_W-1:0] SUM_MAX = {SUM_W{1'b1}};

    localparam logic [2:0] REG_HIGH_CUT_ENABLE = 3'd0;
    localparam logic [2:0] REG_ELECTRON_LOW = 3'd1;
    localparam logic [2:0] REG_ELECTRON_HIGH = 3'd2;
    localparam logic [2:0] REG_MUON_LOW = 3'd3;
    localparam logic [2:0] REG_COUNT_FLOOR = 3'd4;

    localparam logic [15:0] RST_ELECTRON_LOW = 16'd102;
    localparam logic [15:0] RST_ELECTRON_HIGH = 16'd1229;
    localparam logic [15:0] RST_MUON_LOW = 16'd205;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CLASS,
        ST_INIT,
        ST_NORM,
        ST_SQ,
        ST_SAVE,
        ST_MAG,
        ST_TMUL,
        ST_ACC
    } state_t;

    typedef enum logic [1:0] {
        MODE_NONE,
        MODE_TWO_E,
        MODE_DEV
    } mode_t;

    typedef struct packed {
        logic       capture;
        logic       init_log;
        logic       sel_exp;
        logic       norm;
        logic [2:0] norm_idx;
        logic       square;
        logic       save_lo;
        logic       mag;
        logic       tmul;
        logic       acc;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  last;
        logic  out_busy;
    } status_t;

endpackage

FILE: hdl/pdacc_ctrl.sv
// Controller state machine that sequences one bin through the datapath.
module pdacc_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  pdacc_pkg::status_t  status,
    output pdacc_pkg::cmd_t     cmd
);

    pdacc_pkg::state_t state_reg, state_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       sel_reg, sel_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= pdacc_pkg::ST_IDLE;
            cnt_reg <= 5'd0;
            sel_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            sel_reg <= sel_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cnt_next = cnt_reg;
        sel_next = sel_reg;
        cmd = '0;
        cmd.sel_exp = sel_reg;
        cmd.norm_idx = cnt_reg[2:0];
        s_ready = 1'b0;
        case (state_reg)
            pdacc_pkg::ST_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.capture = 1'b1;
                    state_next = pdacc_pkg::ST_CLASS;
                end
            end
            pdacc_pkg::ST_CLASS: begin
                sel_next = 1'b0;
                if (status.mode == pdacc_pkg::MODE_DEV) begin
                    state_next = pdacc_pkg::ST_INIT;
                end else begin
                    state_next = pdacc_pkg::ST_ACC;
                end
            end
            pdacc_pkg::ST_INIT: begin
                cmd.init_log = 1'b1;
                cnt_next = 5'd0;
                state_next = pdacc_pkg::ST_NORM;
            end
            pdacc_pkg::ST_NORM: begin
                cmd.norm = 1'b1;
                if (cnt_reg == 5'd4) begin
                    cnt_next = 5'd0;
                    state_next = pdacc_pkg::ST_SQ;
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            pdacc_pkg::ST_SQ: begin
                cmd.square = 1'b1;
                if (cnt_reg == 5'(pdacc_pkg::LOG_FRAC - 1)) begin
                    cnt_next = 5'd0;
                    if (sel_reg) begin
                        state_next = pdacc_pkg::ST_MAG;
                    end else begin
                        state_next = pdacc_pkg::ST_SAVE;
                    end
                end else begin
                    cnt_next = cnt_reg + 5'd1;
                end
            end
            pdacc_pkg::ST_SAVE: begin
                cmd.save_lo = 1'b1;
                sel_next = 1'b1;
                state_next = pdacc_pkg::ST_INIT;
            end
            pdacc_pkg::ST_MAG: begin
                cmd.mag = 1'b1;
                state_next = pdacc_pkg::ST_TMUL;
            end
            pdacc_pkg::ST_TMUL: begin
                cmd.tmul = 1'b1;
                state_next = pdacc_pkg::ST_ACC;
            end
            pdacc_pkg::ST_ACC: begin
                if (!(status.last && status.out_busy)) begin
                    cmd.acc = 1'b1;
                    state_next = pdacc_pkg::ST_IDLE;
                end
            end
            default: begin
                state_next = pdacc_pkg::ST_IDLE;
            end
        endcase
    end

endmodule

FILE: hdl/pdacc_datapath.sv
// Datapath with configuration registers, shared multiplier, log unit and accumulator.
module pdacc_datapath (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               cfg_we,
    input  logic [2:0]         cfg_addr,
    input  logic [31:0]        cfg_wdata,
    input  logic               s_sample_kind,
    input  logic [15:0]        s_bin_energy,
    input  logic [31:0]        s_observed_count,
    input  logic [31:0]        s_expected_count,
    input  logic               s_last_bin,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [47:0]        m_deviance_sum,
    output logic               m_saturated,
    input  pdacc_pkg::cmd_t    cmd,
    output pdacc_pkg::status_t status
);

    logic        high_cut_reg;
    logic [15:0] e_low_reg, e_high_reg, mu_low_reg;
    logic [31:0] floor_reg;

    logic        kind_reg, last_reg;
    logic [15:0] energy_reg;
    logic [31:0] obs_reg, exp_reg;

    logic [31:0] m_reg;
    logic [4:0]  k_reg;
    logic [23:0] frac_reg;
    logic [pdacc_pkg::LOG_W-1:0] lo_reg;
    logic        neg_reg;
    logic [31:0] mag_reg;
    logic [39:0] t_reg;

    logic [47:0] sum_reg;
    logic        ovf_reg;
    logic        out_valid_reg;
    logic [47:0] out_sum_reg;
    logic        out_sat_reg;

    logic        skip;
    logic [31:0] mul_a, mul_b;
    logic [63:0] prod;
    logic [32:0] sq;
    logic [5:0]  amt;
    logic [31:0] top_bits;
    logic [pdacc_pkg::LOG_W-1:0] le, d;
    logic [40:0] pos, negp;
    logic [41:0] term;
    logic [48:0] inc, total;
    logic [47:0] sum_new;
    logic        ovf_new;

    always_comb begin
        if (!kind_reg) begin
            skip = (high_cut_reg && (energy_reg > e_high_reg)) || (energy_reg < e_low_reg);
        end else begin
            skip = energy_reg < mu_low_reg;
        end
        if (skip) begin
            status.mode = pdacc_pkg::MODE_NONE;
        end else if ((obs_reg > floor_reg) && (exp_reg > floor_reg)) begin
            status.mode = pdacc_pkg::MODE_DEV;
        end else if (obs_reg <= floor_reg) begin
            status.mode = pdacc_pkg::MODE_TWO_E;
        end else begin
            status.mode = pdacc_pkg::MODE_NONE;
        end
        status.last = last_reg;
        status.out_busy = out_valid_reg;
    end

    always_comb begin
        le = {k_reg, frac_reg};
        d = (lo_reg < le) ? (le - lo_reg) : (lo_reg - le);
        if (cmd.mag) begin
            mul_a = {3'd0, d};
            mul_b = pdacc_pkg::LN2_Q32;
        end else if (cmd.tmul) begin
            mul_a = obs_reg;
            mul_b = mag_reg;
        end else begin
            mul_a = m_reg;
            mul_b = m_reg;
        end
        prod = {32'd0, mul_a} * {32'd0, mul_b};
        sq = prod[63:31];
        amt = 6'd16 >> cmd.norm_idx;
        top_bits = m_reg >> (6'd32 - amt);
    end

    always_comb begin
        pos = {9'd0, exp_reg} + (neg_reg ? 41'd0 : {1'b0, t_reg});
        negp = {9'd0, obs_reg} + (neg_reg ? {1'b0, t_reg} : 41'd0);
        term = (pos > negp) ? {pos - negp, 1'b0} : 42'd0;
        case (status.mode)
            pdacc_pkg::MODE_DEV: inc = {7'd0, term};
            pdacc_pkg::MODE_TWO_E: inc = {16'd0, exp_reg, 1'b0};
            default: inc = 49'd0;
        endcase
        total = {1'b0, sum_reg} + inc;
        if (total[48]) begin
            sum_new = pdacc_pkg::SUM_MAX;
            ovf_new = 1'b1;
        end else begin
            sum_new = total[47:0];
            ovf_new = ovf_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            high_cut_reg <= 1'b1;
            e_low_reg <= pdacc_pkg::RST_ELECTRON_LOW;
            e_high_reg <= pdacc_pkg::RST_ELECTRON_HIGH;
            mu_low_reg <= pdacc_pkg::RST_MUON_LOW;
            floor_reg <= 32'd0;
        end else if (cfg_we) begin
            case (cfg_addr)
                pdacc_pkg::REG_HIGH_CUT_ENABLE: high_cut_reg <= cfg_wdata[0];
                pdacc_pkg::REG_ELECTRON_LOW: e_low_reg <= cfg_wdata[15:0];
                pdacc_pkg::REG_ELECTRON_HIGH: e_high_reg <= cfg_wdata[15:0];
                pdacc_pkg::REG_MUON_LOW: mu_low_reg <= cfg_wdata[15:0];
                pdacc_pkg::REG_COUNT_FLOOR: floor_reg <= cfg_wdata;
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            kind_reg <= s_sample_kind;
            energy_reg <= s_bin_energy;
            obs_reg <= s_observed_count;
            exp_reg <= s_expected_count;
            last_reg <= s_last_bin;
        end
        if (cmd.init_log) begin
            m_reg <= cmd.sel_exp ? exp_reg : obs_reg;
            k_reg <= 5'd31;
            frac_reg <= 24'd0;
        end else if (cmd.norm) begin
            if (top_bits == 32'd0) begin
                m_reg <= m_reg << amt;
                k_reg <= k_reg - amt[4:0];
            end
        end else if (cmd.square) begin
            if (sq[32]) begin
                m_reg <= sq[32:1];
                frac_reg <= {frac_reg[22:0], 1'b1};
            end else begin
                m_reg <= sq[31:0];
                frac_reg <= {frac_reg[22:0], 1'b0};
            end
        end
        if (cmd.save_lo) begin
            lo_reg <= {k_reg, frac_reg};
        end
        if (cmd.mag) begin
            mag_reg <= prod[63:32];
            neg_reg <= lo_reg < le;
        end
        if (cmd.tmul) begin
            t_reg <= prod[63:24];
        end
        if (cmd.acc && last_reg) begin
            out_sum_reg <= sum_new;
            out_sat_reg <= ovf_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sum_reg <= 48'd0;
            ovf_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (cmd.acc) begin
                if (last_reg) begin
                    sum_reg <= 48'd0;
                    ovf_reg <= 1'b0;
                    out_valid_reg <= 1'b1;
                end else begin
                    sum_reg <= sum_new;
                    ovf_reg <= ovf_new;
                end
            end
        end
    end

    assign m_valid = out_valid_reg;
    assign m_deviance_sum = out_sum_reg;
    assign m_saturated = out_sat_reg;

endmodule

FILE: hdl/poisson_deviance_accumulator.sv
// Top level of the Poisson deviance accumulator.
// One bin beat is taken at a time. When the deviance is evaluated, it takes
// two base-2 logarithms, each of five normalize steps and 24 squarings on the
// one shared 32x32 multiplier, plus two more multiplies and the accumulate; a
// bin that is cut or at or below the count floor goes straight to the accumulate.
// A result beat is raised after the bin marked last and is held in its own
// register, so the next bins of a new set are taken while it waits; a second
// last bin waits until the first result has been taken.
module poisson_deviance_accumulator (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_addr,
    input  logic [31:0] cfg_wdata,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_sample_kind,
    input  logic [15:0] s_bin_energy,
    input  logic [31:0] s_observed_count,
    input  logic [31:0] s_expected_count,
    input  logic        s_last_bin,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [47:0] m_deviance_sum,
    output logic        m_saturated
);

    pdacc_pkg::cmd_t    cmd;
    pdacc_pkg::status_t status;

    pdacc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    pdacc_datapath u_datapath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_we           (cfg_we),
        .cfg_addr         (cfg_addr),
        .cfg_wdata        (cfg_wdata),
        .s_sample_kind    (s_sample_kind),
        .s_bin_energy     (s_bin_energy),
        .s_observed_count (s_observed_count),
        .s_expected_count (s_expected_count),
        .s_last_bin       (s_last_bin),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_deviance_sum   (m_deviance_sum),
        .m_saturated      (m_saturated),
        .cmd              (cmd),
        .status           (status)
    );

endmodule
